// ----- rtl/prc_pkg.sv -----
// prc_pkg: types, fixed-point constants and elaboration-time table generators
// for the polar/rectangular CORDIC converter. No dependencies.
`default_nettype none

package prc_pkg;

    // internal datapath width and fixed-point scalings
    localparam int DW         = 64;
    localparam int GUARD      = 8;
    localparam int VEC_SHIFT  = 28;
    localparam int ANG_SHIFT  = 60;
    localparam int GAIN_SHIFT = 62;

    // operation codes carried in the action field
    localparam logic ACT_TO_RECT  = 1'b0;
    localparam logic ACT_TO_POLAR = 1'b1;

    // input item
    typedef struct packed {
        logic               action;
        logic [47:0]        radius_in;
        logic signed [31:0] angle_in;
        logic signed [31:0] x_in;
        logic signed [31:0] y_in;
    } t_in;

    // result item
    typedef struct packed {
        logic signed [31:0] x_out;
        logic signed [31:0] y_out;
        logic [47:0]        radius_out;
        logic signed [31:0] angle_out;
        logic               clipped;
    } t_out;

    // vector state carried through the rotation stages
    typedef struct packed {
        logic                   action;
        logic                   neg;
        logic                   zero;
        logic signed [DW-1:0]   x;
        logic signed [DW-1:0]   y;
        logic signed [DW-1:0]   z;
    } t_vec;

    // magnitudes ahead of gain removal
    typedef struct packed {
        logic                   action;
        logic                   zero;
        logic                   neg_x;
        logic                   neg_y;
        logic signed [DW-1:0]   z;
        logic [DW-1:0]          mag_a;
        logic [DW-1:0]          mag_b;
    } t_mag;

    // partial products of the gain multiply
    typedef struct packed {
        logic                   action;
        logic                   zero;
        logic                   neg_x;
        logic                   neg_y;
        logic signed [DW-1:0]   z;
        logic [3:0][63:0]       pa;
        logic [3:0][63:0]       pb;
    } t_pp;

    // full products after gain removal
    typedef struct packed {
        logic                   action;
        logic                   zero;
        logic                   neg_x;
        logic                   neg_y;
        logic signed [DW-1:0]   z;
        logic [127:0]           sum_a;
        logic [127:0]           sum_b;
    } t_sum;

    // one saturated coordinate
    typedef struct packed {
        logic signed [31:0] value;
        logic               clip;
    } t_coord;

    // shift-subtract quotient, used only to build constants at elaboration
    function automatic logic [63:0] const_quot(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        int          b;
        q = '0;
        r = '0;
        for (b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) scaled by 2^60 from the truncated power series, i >= 1
    function automatic logic signed [63:0] atan_pow2(input int i);
        logic signed [63:0] sum;
        logic [63:0]        t;
        int                 k;
        sum = '0;
        for (k = 0; k < 64; k++) begin
            if (i * (2 * k + 1) <= ANG_SHIFT) begin
                t = const_quot(64'd1 << (ANG_SHIFT - i * (2 * k + 1)), 64'(2 * k + 1));
                if ((k & 1) != 0) sum = sum - $signed(t);
                else              sum = sum + $signed(t);
            end
        end
        return sum;
    endfunction

    // atan(1/3) scaled by 2^60
    function automatic logic signed [63:0] atan_third();
        logic signed [63:0] sum;
        logic [63:0]        t;
        logic [63:0]        term;
        int                 k;
        sum = '0;
        t   = const_quot(64'd1 << ANG_SHIFT, 64'd3);
        for (k = 0; k < 64; k++) begin
            if (t != '0) begin
                term = const_quot(t, 64'(2 * k + 1));
                if ((k & 1) != 0) sum = sum - $signed(term);
                else              sum = sum + $signed(term);
                t = const_quot(t, 64'd9);
            end
        end
        return sum;
    endfunction

    // micro-rotation angle of one stage; stage 0 is pi/4
    function automatic logic signed [63:0] atan_entry(input int i);
        logic signed [63:0] v;
        if (i == 0) v = atan_pow2(1) + atan_third();
        else        v = atan_pow2(i);
        return v;
    endfunction

    // 1/K scaled by 2^62, rounded down
    function automatic logic [63:0] inv_gain_calc(input int iters);
        logic [63:0]  p;
        logic [63:0]  y;
        logic [63:0]  c;
        logic [127:0] tgt;
        logic [127:0] sq;
        int           i;
        int           b;
        p = 64'd1 << GAIN_SHIFT;
        for (i = 0; i < 64; i++) begin
            if (i < iters && 2 * i < 63) begin
                p = p - const_quot(p, (64'd1 << (2 * i)) + 64'd1);
            end
        end
        tgt = {64'd0, p} << GAIN_SHIFT;
        y   = '0;
        for (b = 62; b >= 0; b--) begin
            c  = y | (64'd1 << b);
            sq = {64'd0, c} * {64'd0, c};
            if (sq <= tgt) y = c;
        end
        return y;
    endfunction

    // angle constants at 2^-60, and pi at 2^-29 rounded half up
    localparam logic signed [63:0] QUARTER_PI = atan_entry(0);
    localparam logic signed [63:0] PI_FULL    = QUARTER_PI * 4;
    localparam logic signed [63:0] HALF_PI    = QUARTER_PI * 2;
    localparam logic signed [63:0] PI_Q29     = (PI_FULL + (64'sd1 <<< 30)) >>> 31;

endpackage

`default_nettype wire

// ----- rtl/prc_stream_if.sv -----
// prc_stream_if: valid/ready channel carrying one item of a given payload type.
// Used by the converter top level; no dependencies.
`default_nettype none

interface prc_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/prc_pre.sv -----
// prc_pre: entry stage; scales the operands and folds the start angle
// into the convergence range. Depends on prc_pkg.
`default_nettype none

module prc_pre (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_adv,
    input  wire               i_valid,
    input  prc_pkg::t_in      i_item,
    output logic              o_valid,
    output prc_pkg::t_vec     o_vec
);

    logic              r_valid;
    prc_pkg::t_vec     r_vec;
    prc_pkg::t_vec     n_vec;

    logic signed [63:0] w_z_rot;
    logic signed [63:0] w_x_vec;
    logic signed [63:0] w_y_vec;

    // operand scaling
    assign w_z_rot = {i_item.angle_in[31], i_item.angle_in, 31'd0};
    assign w_x_vec = 64'(i_item.x_in) <<< prc_pkg::VEC_SHIFT;
    assign w_y_vec = 64'(i_item.y_in) <<< prc_pkg::VEC_SHIFT;

    // start vector and angle
    always_comb begin
        n_vec        = '0;
        n_vec.action = i_item.action;
        if (i_item.action == prc_pkg::ACT_TO_RECT) begin
            n_vec.x = $signed(64'(i_item.radius_in) << prc_pkg::GUARD);
            n_vec.y = '0;
            if (w_z_rot > prc_pkg::HALF_PI) begin
                n_vec.z   = w_z_rot - prc_pkg::PI_FULL;
                n_vec.neg = 1'b1;
            end else if (w_z_rot < -prc_pkg::HALF_PI) begin
                n_vec.z   = w_z_rot + prc_pkg::PI_FULL;
                n_vec.neg = 1'b1;
            end else begin
                n_vec.z   = w_z_rot;
            end
        end else begin
            n_vec.zero = (i_item.x_in == '0) && (i_item.y_in == '0);
            // left half plane: turn by pi first
            if (i_item.x_in[31]) begin
                n_vec.x = -w_x_vec;
                n_vec.y = -w_y_vec;
                n_vec.z = i_item.y_in[31] ? -prc_pkg::PI_FULL : prc_pkg::PI_FULL;
            end else begin
                n_vec.x = w_x_vec;
                n_vec.y = w_y_vec;
                n_vec.z = '0;
            end
        end
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    // stage data
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_vec <= n_vec;
        end
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;

endmodule

`default_nettype wire

// ----- rtl/prc_cordic_stage.sv -----
// prc_cordic_stage: one registered CORDIC micro-rotation, rotation or
// vectoring chosen by the item's action. Depends on prc_pkg.
`default_nettype none

module prc_cordic_stage #(
    parameter int STAGE = 0
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_adv,
    input  wire               i_valid,
    input  prc_pkg::t_vec     i_vec,
    output logic              o_valid,
    output prc_pkg::t_vec     o_vec
);

    localparam logic signed [63:0] ATAN = prc_pkg::atan_entry(STAGE);

    logic              r_valid;
    prc_pkg::t_vec     r_vec;
    prc_pkg::t_vec     n_vec;

    logic signed [63:0] w_x;
    logic signed [63:0] w_y;
    logic signed [63:0] w_z;
    logic signed [63:0] w_xs;
    logic signed [63:0] w_ys;
    logic               w_up;

    assign w_x  = i_vec.x;
    assign w_y  = i_vec.y;
    assign w_z  = i_vec.z;
    assign w_xs = w_x >>> STAGE;
    assign w_ys = w_y >>> STAGE;

    // direction: drive z to zero when rotating, y to zero when vectoring
    assign w_up = (i_vec.action == prc_pkg::ACT_TO_POLAR) ? w_y[63] : !w_z[63];

    always_comb begin
        n_vec = i_vec;
        if (w_up) begin
            n_vec.x = w_x - w_ys;
            n_vec.y = w_y + w_xs;
            n_vec.z = w_z - ATAN;
        end else begin
            n_vec.x = w_x + w_ys;
            n_vec.y = w_y - w_xs;
            n_vec.z = w_z + ATAN;
        end
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    // stage data
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_vec <= n_vec;
        end
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;

endmodule

`default_nettype wire

// ----- rtl/prc_gain.sv -----
// prc_gain: removes the CORDIC gain; magnitude stage, 32x32 partial product
// stage and product sum stage. Depends on prc_pkg.
`default_nettype none

module prc_gain #(
    parameter int ITERATIONS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_adv,
    input  wire               i_valid,
    input  prc_pkg::t_vec     i_vec,
    output logic              o_valid,
    output prc_pkg::t_sum     o_sum
);

    localparam logic [63:0]  INV_GAIN = prc_pkg::inv_gain_calc(ITERATIONS);
    // half an lsb of the radius result
    localparam logic [127:0] RND = 128'd1 << (prc_pkg::GAIN_SHIFT + prc_pkg::VEC_SHIFT
                                              - FRAC_BITS - 1);

    logic           r_v_mag;
    logic           r_v_pp;
    logic           r_v_sum;
    prc_pkg::t_mag  r_mag;
    prc_pkg::t_mag  n_mag;
    prc_pkg::t_pp   r_pp;
    prc_pkg::t_pp   n_pp;
    prc_pkg::t_sum  r_sum;
    prc_pkg::t_sum  n_sum;

    logic           w_x_pos;
    logic           w_y_pos;

    assign w_x_pos = !i_vec.x[63] && (i_vec.x != '0);
    assign w_y_pos = !i_vec.y[63] && (i_vec.y != '0);

    // magnitudes and final signs
    always_comb begin
        n_mag        = '0;
        n_mag.action = i_vec.action;
        n_mag.zero   = i_vec.zero;
        n_mag.z      = i_vec.z;
        n_mag.neg_x  = i_vec.neg ? w_x_pos : i_vec.x[63];
        n_mag.neg_y  = i_vec.neg ? w_y_pos : i_vec.y[63];
        n_mag.mag_b  = i_vec.y[63] ? 64'(-i_vec.y) : 64'(i_vec.y);
        if (i_vec.action == prc_pkg::ACT_TO_POLAR) begin
            n_mag.mag_a = i_vec.x[63] ? '0 : 64'(i_vec.x);
        end else begin
            n_mag.mag_a = i_vec.x[63] ? 64'(-i_vec.x) : 64'(i_vec.x);
        end
    end

    // partial products, halves of 32 bits
    always_comb begin
        n_pp        = '0;
        n_pp.action = r_mag.action;
        n_pp.zero   = r_mag.zero;
        n_pp.neg_x  = r_mag.neg_x;
        n_pp.neg_y  = r_mag.neg_y;
        n_pp.z      = r_mag.z;
        n_pp.pa[0]  = 64'(r_mag.mag_a[31:0])  * 64'(INV_GAIN[31:0]);
        n_pp.pa[1]  = 64'(r_mag.mag_a[31:0])  * 64'(INV_GAIN[63:32]);
        n_pp.pa[2]  = 64'(r_mag.mag_a[63:32]) * 64'(INV_GAIN[31:0]);
        n_pp.pa[3]  = 64'(r_mag.mag_a[63:32]) * 64'(INV_GAIN[63:32]);
        n_pp.pb[0]  = 64'(r_mag.mag_b[31:0])  * 64'(INV_GAIN[31:0]);
        n_pp.pb[1]  = 64'(r_mag.mag_b[31:0])  * 64'(INV_GAIN[63:32]);
        n_pp.pb[2]  = 64'(r_mag.mag_b[63:32]) * 64'(INV_GAIN[31:0]);
        n_pp.pb[3]  = 64'(r_mag.mag_b[63:32]) * 64'(INV_GAIN[63:32]);
    end

    // product sums; radius rounding folded in
    always_comb begin
        n_sum        = '0;
        n_sum.action = r_pp.action;
        n_sum.zero   = r_pp.zero;
        n_sum.neg_x  = r_pp.neg_x;
        n_sum.neg_y  = r_pp.neg_y;
        n_sum.z      = r_pp.z;
        n_sum.sum_a  = {r_pp.pa[3], r_pp.pa[0]}
                     + {32'd0, r_pp.pa[1], 32'd0}
                     + {32'd0, r_pp.pa[2], 32'd0}
                     + ((r_pp.action == prc_pkg::ACT_TO_POLAR) ? RND : 128'd0);
        n_sum.sum_b  = {r_pp.pb[3], r_pp.pb[0]}
                     + {32'd0, r_pp.pb[1], 32'd0}
                     + {32'd0, r_pp.pb[2], 32'd0};
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_mag <= 1'b0;
            r_v_pp  <= 1'b0;
            r_v_sum <= 1'b0;
        end else if (i_adv) begin
            r_v_mag <= i_valid;
            r_v_pp  <= r_v_mag;
            r_v_sum <= r_v_pp;
        end
    end

    // stage data
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_mag <= n_mag;
            r_pp  <= n_pp;
            r_sum <= n_sum;
        end
    end

    assign o_valid = r_v_sum;
    assign o_sum   = r_sum;

endmodule

`default_nettype wire

// ----- rtl/polar_rectangular_converter_core.sv -----
// polar_rectangular_converter_core: top level of the pipelined CORDIC
// converter. Depends on prc_pkg, prc_stream_if, prc_pre, prc_cordic_stage, prc_gain.
//
// Usage:
//   i_in carries one item per handshake: action 0 turns radius_in (Q32.16) and
//   angle_in (Q3.29 radians) into integer x_out/y_out with a clipped flag;
//   action 1 turns integer x_in/y_in into radius_out and angle_out.
//   o_out carries one result per item, in order; unused fields read 0.
//   Throughput: one item per cycle while the skid is empty. Each item passes
//   the entry register, which loads at the accepting edge, one stage per
//   micro-rotation, three gain-multiply stages and the output register,
//   which drives o_out.valid.
//   Stall: the output register is backed by a one-item skid register; when the
//   receiver holds off, the next item lands in the skid and the pipeline then
//   freezes as a whole with i_in.ready low until the output drains.
//   Reset: synchronous, active low; empties every stage, the output register
//   and the skid. No configuration.
`default_nettype none

module polar_rectangular_converter_core #(
    parameter int ITERATIONS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    prc_stream_if.sink   i_in,
    prc_stream_if.source o_out
);

    localparam int S_ROT = prc_pkg::GAIN_SHIFT + prc_pkg::GUARD + FRAC_BITS;
    localparam int S_VEC = prc_pkg::GAIN_SHIFT + prc_pkg::VEC_SHIFT - FRAC_BITS;
    localparam logic signed [63:0] PI29_POS = prc_pkg::PI_Q29;
    localparam logic signed [63:0] PI29_NEG = -prc_pkg::PI_Q29;
    localparam logic signed [31:0] PI29_32  = prc_pkg::PI_Q29[31:0];

    logic                w_adv;
    logic                w_v   [0:ITERATIONS];
    prc_pkg::t_vec       w_vec [0:ITERATIONS];
    logic                w_sum_valid;
    prc_pkg::t_sum       w_sum;

    logic                r_out_valid;
    logic                r_sk_valid;
    prc_pkg::t_out       r_out;
    prc_pkg::t_out       r_sk;
    prc_pkg::t_out       w_res;
    logic                w_take;

    logic [127:0]        w_qx;
    logic [127:0]        w_qy;
    logic [127:0]        w_rad;
    prc_pkg::t_coord     w_cx;
    prc_pkg::t_coord     w_cy;
    logic signed [63:0]  w_z;
    logic signed [63:0]  w_zq;
    logic signed [63:0]  w_zc;

    // whole pipeline moves while the skid is empty
    assign w_adv      = !r_sk_valid;
    assign i_in.ready = w_adv;
    assign w_take     = r_out_valid && o_out.ready;

    // entry stage
    prc_pre u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_in.valid),
        .i_item  (i_in.payload),
        .o_valid (w_v[0]),
        .o_vec   (w_vec[0])
    );

    // micro-rotation stages
    for (genvar g = 0; g < ITERATIONS; g++) begin : g_stage
        prc_cordic_stage #(
            .STAGE (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (w_v[g]),
            .i_vec   (w_vec[g]),
            .o_valid (w_v[g+1]),
            .o_vec   (w_vec[g+1])
        );
    end

    // gain removal
    prc_gain #(
        .ITERATIONS (ITERATIONS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_v[ITERATIONS]),
        .i_vec   (w_vec[ITERATIONS]),
        .o_valid (w_sum_valid),
        .o_sum   (w_sum)
    );

    // truncate toward zero and saturate one coordinate
    function automatic prc_pkg::t_coord fin_coord(input logic [127:0] q, input logic neg);
        prc_pkg::t_coord c;
        c = '0;
        if (!neg) begin
            if (q > 128'h7FFF_FFFF) begin
                c.clip  = 1'b1;
                c.value = 32'sh7FFF_FFFF;
            end else begin
                c.value = q[31:0];
            end
        end else begin
            if (q > 128'h8000_0000) begin
                c.clip  = 1'b1;
                c.value = 32'sh8000_0000;
            end else begin
                c.value = 32'(32'd0 - q[31:0]);
            end
        end
        return c;
    endfunction

    // result formatting
    assign w_qx  = w_sum.sum_a >> S_ROT;
    assign w_qy  = w_sum.sum_b >> S_ROT;
    assign w_rad = w_sum.sum_a >> S_VEC;
    assign w_cx  = fin_coord(w_qx, w_sum.neg_x);
    assign w_cy  = fin_coord(w_qy, w_sum.neg_y);
    assign w_z   = w_sum.z;
    assign w_zq  = (w_z + (64'sd1 <<< 30)) >>> 31;

    // angle clamp to plus or minus pi
    always_comb begin
        if (w_zq > PI29_POS)      w_zc = PI29_POS;
        else if (w_zq < PI29_NEG) w_zc = PI29_NEG;
        else                      w_zc = w_zq;
    end

    always_comb begin
        w_res = '0;
        if (w_sum.action == prc_pkg::ACT_TO_POLAR) begin
            w_res.radius_out = (|w_rad[127:48]) ? '1 : w_rad[47:0];
            w_res.angle_out  = w_sum.zero ? '0 : w_zc[31:0];
        end else begin
            w_res.x_out   = w_cx.value;
            w_res.y_out   = w_cy.value;
            w_res.clipped = w_cx.clip | w_cy.clip;
        end
    end

    // output register and skid control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (r_sk_valid) begin
            if (w_take) begin
                r_sk_valid <= 1'b0;
            end
        end else if (w_sum_valid) begin
            if (!r_out_valid || w_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_sk_valid  <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register and skid data
    always_ff @(posedge i_clk) begin
        if (r_sk_valid) begin
            if (w_take) begin
                r_out <= r_sk;
            end
        end else if (w_sum_valid) begin
            if (!r_out_valid || w_take) begin
                r_out <= w_res;
            end else begin
                r_sk  <= w_res;
            end
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // skid holds an item only behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |-> r_out_valid)
        else $error("skid item without output item");

    // skid fills only when the receiver held off
    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sk_valid) |-> $past(o_out.valid && !o_out.ready))
        else $error("skid filled without a stall");

    // polar fields and rectangular fields never both carry data
    a_fields_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.payload.radius_out != '0 || o_out.payload.angle_out != '0)
        |-> o_out.payload.x_out == '0 && o_out.payload.y_out == '0
            && !o_out.payload.clipped)
        else $error("mixed polar and rectangular result");

    // a clipped result sits on a rail
    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.payload.clipped
        |-> o_out.payload.x_out == 32'sh7FFF_FFFF || o_out.payload.x_out == 32'sh8000_0000
            || o_out.payload.y_out == 32'sh7FFF_FFFF || o_out.payload.y_out == 32'sh8000_0000)
        else $error("clipped flag without saturated coordinate");

    // angle stays within plus or minus pi
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.payload.angle_out <= PI29_32
                        && o_out.payload.angle_out >= -PI29_32)
        else $error("angle outside plus or minus pi");

endmodule

`default_nettype wire

// ----- verif/polar_rectangular_converter_core_tb.sv -----
// polar_rectangular_converter_core_tb: self-checking testbench for the CORDIC polar/rectangular
// converter, with its own bit-exact predictor, valid/ready driver and result monitor.
// Depends on prc_pkg, prc_stream_if and polar_rectangular_converter_core.

module polar_rectangular_converter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITERS       = 32;
    localparam int FRAC        = 16;
    localparam int LATENCY     = ITERS + 5;
    localparam int COORD_GUARD = 8;
    localparam int VEC_SCALE   = 28;
    localparam int ANGLE_FRAC  = 60;
    localparam int GAIN_FRAC   = 62;
    localparam int ROT_SHIFT   = GAIN_FRAC + COORD_GUARD + FRAC;
    localparam int VEC_ROUND   = GAIN_FRAC + VEC_SCALE - FRAC;
    localparam int RANDOM_ITEMS_PER_PHASE = 275;

    logic i_clk = 1'b0;
    logic i_rst_n;

    prc_stream_if #(.t_payload(prc_pkg::t_in))  in_if ();
    prc_stream_if #(.t_payload(prc_pkg::t_out)) out_if ();

    polar_rectangular_converter_core #(
        .ITERATIONS(ITERS),
        .FRAC_BITS (FRAC)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // micro-rotation angles at 2^-60, pi at 2^-60, inverse gain at 2^-62
    longint      atan_table[ITERS];
    longint      pi_q60;
    logic [63:0] inv_gain_q62;

    prc_pkg::t_in  pending_items[$];
    prc_pkg::t_out expected_results[$];
    int   queued_count = 0;
    int   results_seen = 0;
    int   error_count = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic in_taken = 1'b0;

    always #5 i_clk = ~i_clk;

    task automatic report_error(input string what);
        error_count++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // atan(2^-i) at 2^-60 from the truncated power series, i >= 1
    function automatic longint atan_inv_pow2(input int i);
        longint sum;
        longint t;
        int     k;
        sum = 0;
        for (k = 0; i * (2 * k + 1) <= ANGLE_FRAC; k++) begin
            t = (64'sd1 <<< (ANGLE_FRAC - i * (2 * k + 1))) / longint'(2 * k + 1);
            if (k % 2 != 0) sum -= t;
            else            sum += t;
        end
        return sum;
    endfunction

    // remove the gain, truncate toward zero and saturate; returns {clip, value}
    function automatic logic [32:0] scale_coord(input longint v);
        logic [63:0]  m;
        logic [127:0] q;
        m = (v < 0) ? 64'(-v) : 64'(v);
        q = ({64'd0, m} * {64'd0, inv_gain_q62}) >> ROT_SHIFT;
        if (v >= 0) begin
            if (q > 128'h7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
            return {1'b0, q[31:0]};
        end
        if (q > 128'h8000_0000) return {1'b1, 32'h8000_0000};
        return {1'b0, 32'd0 - q[31:0]};
    endfunction

    // expected result of one item
    function automatic prc_pkg::t_out convert_coords(input prc_pkg::t_in item);
        prc_pkg::t_out r;
        longint       x;
        longint       y;
        longint       z;
        longint       dx;
        longint       dy;
        longint       q;
        longint       lim;
        logic         neg;
        logic [32:0]  cx;
        logic [32:0]  cy;
        logic [127:0] prod;
        int           i;
        r = '0;
        if (item.action == prc_pkg::ACT_TO_RECT) begin
            z   = longint'($signed(item.angle_in)) * (64'sd1 <<< 31);
            neg = 1'b0;
            // fold angles beyond a quarter turn by pi and negate afterwards
            if (z > pi_q60 / 2) begin
                z   = z - pi_q60;
                neg = 1'b1;
            end else if (z < -(pi_q60 / 2)) begin
                z   = z + pi_q60;
                neg = 1'b1;
            end
            x = longint'({8'd0, item.radius_in, 8'd0});
            y = 0;
            for (i = 0; i < ITERS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - atan_table[i];
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + atan_table[i];
                end
            end
            if (neg) begin
                x = -x;
                y = -y;
            end
            cx = scale_coord(x);
            cy = scale_coord(y);
            r.x_out   = cx[31:0];
            r.y_out   = cy[31:0];
            r.clipped = cx[32] | cy[32];
        end else if (item.x_in != 0 || item.y_in != 0) begin
            x = longint'($signed(item.x_in)) <<< VEC_SCALE;
            y = longint'($signed(item.y_in)) <<< VEC_SCALE;
            z = 0;
            // left half plane: turn by pi first
            if (x < 0) begin
                z = (y >= 0) ? pi_q60 : -pi_q60;
                x = -x;
                y = -y;
            end
            for (i = 0; i < ITERS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x = x + dx;
                    y = y - dy;
                    z = z + atan_table[i];
                end else begin
                    x = x - dx;
                    y = y + dy;
                    z = z - atan_table[i];
                end
            end
            if (x < 0) x = 0;
            // radius rounded half up, clamped to 48 bits
            prod = {64'd0, 64'(x)} * {64'd0, inv_gain_q62} + (128'd1 << (VEC_ROUND - 1));
            prod = prod >> VEC_ROUND;
            r.radius_out = (prod > 128'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : prod[47:0];
            // angle rounded half up to 2^-29, clamped to +-pi
            lim = (pi_q60 + (64'sd1 <<< 30)) >>> 31;
            q   = (z + (64'sd1 <<< 30)) >>> 31;
            if (q > lim)  q = lim;
            if (q < -lim) q = -lim;
            r.angle_out = q[31:0];
        end
        return r;
    endfunction

    // constant tables
    initial begin : build_tables
        longint       t;
        longint       term;
        longint       quarter;
        logic [63:0]  p;
        logic [63:0]  c;
        logic [127:0] target;
        logic [127:0] sq;
        int           i;
        int           b;
        int           k;
        // pi/4 = atan(1/2) + atan(1/3)
        quarter = atan_inv_pow2(1);
        t = (64'sd1 <<< ANGLE_FRAC) / 3;
        k = 0;
        while (t != 0) begin
            term = t / longint'(2 * k + 1);
            if (k % 2 != 0) quarter -= term;
            else            quarter += term;
            t = t / 9;
            k++;
        end
        atan_table[0] = quarter;
        for (i = 1; i < ITERS; i++) atan_table[i] = atan_inv_pow2(i);
        pi_q60 = 4 * quarter;
        // 1/K^2 as a product, then its square root by bisection, rounded down
        p = 64'd1 << GAIN_FRAC;
        for (i = 0; i < ITERS; i++) begin
            if (2 * i < 63) p = p - p / ((64'd1 << (2 * i)) + 64'd1);
        end
        target = {64'd0, p} << GAIN_FRAC;
        inv_gain_q62 = '0;
        for (b = 62; b >= 0; b--) begin
            c  = inv_gain_q62 | (64'd1 << b);
            sq = {64'd0, c} * {64'd0, c};
            if (sq <= target) inv_gain_q62 = c;
        end
    end

    // item driver and receiver backpressure, on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid  <= 1'b0;
            out_if.ready <= 1'b0;
        end else begin
            if (!in_if.valid || in_taken) begin
                in_taken = 1'b0;
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_if.valid   <= 1'b1;
                    in_if.payload <= pending_items.pop_front();
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
            out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // predict on accepted items, check accepted results
    always @(posedge i_clk) begin : monitor
        prc_pkg::t_out want;
        prc_pkg::t_out got;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                expected_results.push_back(convert_coords(in_if.payload));
                in_taken = 1'b1;
            end
            if (out_if.valid && out_if.ready) begin
                got = out_if.payload;
                if (expected_results.size() == 0) begin
                    report_error($sformatf("result %h with no item outstanding", got));
                end else begin
                    want = expected_results.pop_front();
                    results_seen++;
                    if (got.x_out !== want.x_out)
                        report_error($sformatf("x_out got %0d expected %0d",
                                               got.x_out, want.x_out));
                    if (got.y_out !== want.y_out)
                        report_error($sformatf("y_out got %0d expected %0d",
                                               got.y_out, want.y_out));
                    if (got.radius_out !== want.radius_out)
                        report_error($sformatf("radius_out got %h expected %h",
                                               got.radius_out, want.radius_out));
                    if (got.angle_out !== want.angle_out)
                        report_error($sformatf("angle_out got %0d expected %0d",
                                               got.angle_out, want.angle_out));
                    if (got.clipped !== want.clipped)
                        report_error($sformatf("clipped got %b expected %b",
                                               got.clipped, want.clipped));
                end
            end
        end
    end

    // queue one item; fields the action ignores get random content
    task automatic queue_item(input logic act, input logic [47:0] rad, input logic [31:0] ang,
                              input logic [31:0] xv, input logic [31:0] yv);
        prc_pkg::t_in item;
        item.action    = act;
        item.radius_in = rad;
        item.angle_in  = ang;
        item.x_in      = xv;
        item.y_in      = yv;
        if (act == prc_pkg::ACT_TO_RECT) begin
            item.x_in = $urandom;
            item.y_in = $urandom;
        end else begin
            item.radius_in = 48'({$urandom, $urandom});
            item.angle_in  = $urandom;
        end
        pending_items.push_back(item);
        queued_count++;
    endtask

    initial begin : stimulus
        int send_pct[4];
        int recv_pct[4];
        int ph;
        int n;
        send_pct = '{0, 56, 0, 23};
        recv_pct = '{0, 0, 56, 23};
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.payload = '0;
        out_if.ready  = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // polar to rectangular: zero, full scale, the 2^31 boundaries, angle extremes and folds
        queue_item(prc_pkg::ACT_TO_RECT, 48'd0, 32'd0, 32'd0, 32'd0);
        queue_item(prc_pkg::ACT_TO_RECT, 48'hFFFF_FFFF_FFFF, 32'd0, 32'd0, 32'd0);
        queue_item(prc_pkg::ACT_TO_RECT, 48'd65536, 32'd0, 32'd0, 32'd0);
        queue_item(prc_pkg::ACT_TO_RECT, 48'd1, 32'h7FFF_FFFF, 32'd0, 32'd0);
        queue_item(prc_pkg::ACT_TO_RECT, 48'd100 << 16, 32'h8000_0000, 32'd0, 32'd0);
        queue_item(prc_pkg::ACT_TO_RECT, 48'd1000 << 16, 32'sd843314857, 32'd0, 32'd0);
        queue_item(prc_pkg::ACT_TO_RECT, 48'd1000 << 16, -32'sd843314857, 32'd0, 32'd0);
        queue_item(prc_pkg::ACT_TO_RECT, 48'd1000 << 16, 32'sd1686629713, 32'd0, 32'd0);
        queue_item(prc_pkg::ACT_TO_RECT, 48'd1000 << 16, -32'sd1686629713, 32'd0, 32'd0);
        queue_item(prc_pkg::ACT_TO_RECT, 48'h8000_0000_0000, 32'sd1686629713, 32'd0, 32'd0);
        queue_item(prc_pkg::ACT_TO_RECT, 48'h7FFF_FFFF_FFFF, 32'd0, 32'd0, 32'd0);
        queue_item(prc_pkg::ACT_TO_RECT, 48'h0000_0000_FFFF, 32'd1, 32'd0, 32'd0);
        // rectangular to polar: origin, corners, negative x on both sides of the axis
        queue_item(prc_pkg::ACT_TO_POLAR, 48'd0, 32'd0, 32'd0, 32'd0);
        queue_item(prc_pkg::ACT_TO_POLAR, 48'd0, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_item(prc_pkg::ACT_TO_POLAR, 48'd0, 32'd0, 32'h8000_0000, 32'h8000_0000);
        queue_item(prc_pkg::ACT_TO_POLAR, 48'd0, 32'd0, 32'h8000_0000, 32'd0);
        queue_item(prc_pkg::ACT_TO_POLAR, 48'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_item(prc_pkg::ACT_TO_POLAR, 48'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
        queue_item(prc_pkg::ACT_TO_POLAR, 48'd0, 32'd0, 32'd0, 32'h8000_0000);
        queue_item(prc_pkg::ACT_TO_POLAR, 48'd0, 32'd0, 32'd0, 32'h7FFF_FFFF);
        queue_item(prc_pkg::ACT_TO_POLAR, 48'd0, 32'd0, 32'd1, 32'd0);
        queue_item(prc_pkg::ACT_TO_POLAR, 48'd0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_item(prc_pkg::ACT_TO_POLAR, 48'd0, 32'd0, 32'd3, 32'd4);
        queue_item(prc_pkg::ACT_TO_POLAR, 48'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
        while (results_seen != queued_count) @(negedge i_clk);

        // random items over the idle/stall phases, magnitudes spread by random shifts
        for (ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            for (n = 0; n < RANDOM_ITEMS_PER_PHASE; n++) begin
                queue_item($urandom_range(0, 1) ? prc_pkg::ACT_TO_POLAR : prc_pkg::ACT_TO_RECT,
                           48'({$urandom, $urandom}) >> $urandom_range(0, 47),
                           $urandom,
                           $signed($urandom) >>> $urandom_range(0, 31),
                           $signed($urandom) >>> $urandom_range(0, 31));
            end
            while (results_seen != queued_count) @(negedge i_clk);
        end

        repeat (LATENCY + 10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- polar_rectangular_converter_core.f -----
rtl/prc_pkg.sv
rtl/prc_stream_if.sv
rtl/prc_pre.sv
rtl/prc_cordic_stage.sv
rtl/prc_gain.sv
rtl/polar_rectangular_converter_core.sv
verif/polar_rectangular_converter_core_tb.sv
